### rtl/ascii_decimal_to_fixed_unit_defines.svh
// ============================================================================
// ascii_decimal_to_fixed_unit assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef ASCII_DECIMAL_TO_FIXED_UNIT_DEFINES_SVH
`define ASCII_DECIMAL_TO_FIXED_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge
`define ADTF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("adtf check failed");

// Antecedent implies consequent in the same cycle
`define ADTF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adtf implication failed");

// Antecedent implies consequent in the next cycle
`define ADTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adtf next-cycle check failed");

`else

`define ADTF_ASSERT(lbl, cond)
`define ADTF_ASSERT_IMPL(lbl, ante, cons)
`define ADTF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/adtf_pkg.sv
// ============================================================================
// adtf_pkg
// Shared types, character codes, token kinds, status codes and the fraction
// weight table for the ASCII decimal to fixed-point converter.
// ============================================================================
`default_nettype none

package adtf_pkg;

    // Number format
    localparam int INT_BITS        = 16;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int INT_N_W  = INT_BITS + 4;
    localparam int MAG_W    = 64;
    localparam int LIMIT_SH = (INT_BITS + FRAC_BITS - 1 > 31) ? 31
                                                              : INT_BITS + FRAC_BITS - 1;

    localparam logic [INT_BITS-1:0] INT_CAP   = {1'b1, {(INT_BITS-1){1'b0}}};
    localparam logic [MAG_W-1:0]    MAG_TOP   = MAG_W'(1) << LIMIT_SH;
    localparam logic [3:0]          MAX_DIGIT = 4'(MAX_FRAC_DIGITS);

    // Input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Token kinds
    typedef logic [2:0] tok_kind_t;
    localparam tok_kind_t TK_DIGIT = 3'd0;
    localparam tok_kind_t TK_PLUS  = 3'd1;
    localparam tok_kind_t TK_MINUS = 3'd2;
    localparam tok_kind_t TK_DOT   = 3'd3;
    localparam tok_kind_t TK_END   = 3'd4;
    localparam tok_kind_t TK_OTHER = 3'd5;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    // Result status
    typedef logic [1:0] status_t;
    localparam status_t ST_OK  = 2'd0;
    localparam status_t ST_BAD = 2'd1;
    localparam status_t ST_SAT = 2'd2;

    // round(2^32 / 10^k) for fraction digit position k
    function automatic logic [31:0] frac_weight(input logic [3:0] k);
        logic [31:0] w;
        case (k)
            4'd1:    w = 32'd429496730;
            4'd2:    w = 32'd42949673;
            4'd3:    w = 32'd4294967;
            4'd4:    w = 32'd429497;
            4'd5:    w = 32'd42950;
            4'd6:    w = 32'd4295;
            4'd7:    w = 32'd429;
            4'd8:    w = 32'd43;
            4'd9:    w = 32'd4;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/adtf_front.sv
// ============================================================================
// adtf_front
// Accepts characters and classifies each into a token for the parse queue.
// ============================================================================
`default_nettype none

module adtf_front
    import adtf_pkg::*;
(
    input  wire logic [7:0] character,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic       queue_full,
    output      logic       push,
    output      token_t     push_token
);

    logic [7:0] digit_off;

    assign digit_off = character - CH_ZERO;
    assign in_stall  = queue_full;
    assign push      = in_valid && !queue_full;

    always_comb
    begin
        push_token.digit = digit_off[3:0];
        unique case (character) inside
            CH_NUL:            push_token.kind = TK_END;
            CH_PLUS:           push_token.kind = TK_PLUS;
            CH_MINUS:          push_token.kind = TK_MINUS;
            CH_DOT:            push_token.kind = TK_DOT;
            [CH_ZERO:CH_NINE]: push_token.kind = TK_DIGIT;
            default:           push_token.kind = TK_OTHER;
        endcase
    end

endmodule

`default_nettype wire

### rtl/adtf_queue.sv
// ============================================================================
// adtf_queue
// Small token FIFO between the classifier and the parser.
// ============================================================================
`default_nettype none

module adtf_queue
    import adtf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t push_token,
    output      logic   full,
    input  wire logic   pop,
    output      token_t pop_token,
    output      logic   not_empty
);

    token_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_token = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

`default_nettype wire

### rtl/adtf_back.sv
// ============================================================================
// adtf_back
// Parser: consumes one token per cycle while tokens are queued, except a
// terminator held behind a stalled result; accumulates integer and fraction
// parts, and on the terminator loads the fixed-point result register.
`default_nettype none

`include "ascii_decimal_to_fixed_unit_defines.svh"

module adtf_back
    import adtf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               not_empty,
    input  wire token_t             pop_token,
    output      logic               pop,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic signed [31:0] value,
    output      status_t            status
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_INT   = 2'd1;
    localparam logic [1:0] PH_FRAC  = 2'd2;
    localparam logic [1:0] PH_BAD   = 2'd3;

    logic [1:0]          phase_reg,    phase_next;
    logic                neg_reg,      neg_next;
    logic                sat_reg,      sat_next;
    logic [INT_BITS-1:0] int_acc_reg,  int_acc_next;
    logic [31:0]         frac_acc_reg, frac_acc_next;
    logic [3:0]          frac_cnt_reg, frac_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         value_reg,    value_next;
    status_t             status_reg,   status_next;

    logic                out_free;
    logic                pop_end;
    logic [INT_N_W-1:0]  int_n;
    logic [3:0]          frac_pos;
    logic [31:0]         frac_term;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    mag_c;
    logic                over;
    logic [31:0]         mag32;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = not_empty && ((pop_token.kind != TK_END) || out_free);
    assign pop_end   = pop && (pop_token.kind == TK_END);

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // Integer step: acc * 10 + digit
    assign int_n = (INT_N_W'(int_acc_reg) * INT_N_W'(10)) + INT_N_W'(pop_token.digit);

    // Fraction step: digit times weight of the next position
    assign frac_pos  = frac_cnt_reg + 4'd1;
    assign frac_term = frac_weight(frac_pos) * {28'd0, pop_token.digit};

    // Result magnitude, clamp, sign
    assign mag   = (MAG_W'(int_acc_reg) << FRAC_BITS)
                 | MAG_W'(frac_acc_reg >> (32 - FRAC_BITS));
    assign over  = neg_reg ? (mag > MAG_TOP) : (mag >= MAG_TOP);
    assign mag_c = over ? (neg_reg ? MAG_TOP : MAG_TOP - MAG_W'(1)) : mag;
    assign mag32 = mag_c[31:0];

    always_comb
    begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        int_acc_next   = int_acc_reg;
        frac_acc_next  = frac_acc_reg;
        frac_cnt_next  = frac_cnt_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (pop_end)
        begin
            out_valid_next = 1'b1;
            if (phase_reg == PH_START || phase_reg == PH_BAD)
            begin
                value_next  = '0;
                status_next = ST_BAD;
            end
            else
            begin
                value_next  = neg_reg ? (32'd0 - mag32) : mag32;
                status_next = (sat_reg || over) ? ST_SAT : ST_OK;
            end
            // Return to start for the next string
            phase_next    = PH_START;
            neg_next      = 1'b0;
            sat_next      = 1'b0;
            int_acc_next  = '0;
            frac_acc_next = '0;
            frac_cnt_next = '0;
        end
        else if (pop)
        begin
            unique case (phase_reg)
                PH_START, PH_INT:
                begin
                    unique case (pop_token.kind) inside
                        TK_PLUS, TK_MINUS:
                        begin
                            if (phase_reg == PH_START)
                            begin
                                neg_next   = (pop_token.kind == TK_MINUS);
                                phase_next = PH_INT;
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                            end
                        end
                        TK_DOT:
                        begin
                            phase_next = PH_FRAC;
                        end
                        TK_DIGIT:
                        begin
                            phase_next = PH_INT;
                            if (int_n > INT_N_W'(INT_CAP))
                            begin
                                int_acc_next = INT_CAP;
                                sat_next     = 1'b1;
                            end
                            else
                            begin
                                int_acc_next = int_n[INT_BITS-1:0];
                            end
                        end
                        default:
                        begin
                            phase_next = PH_BAD;
                        end
                    endcase
                end
                PH_FRAC:
                begin
                    if (pop_token.kind == TK_DIGIT)
                    begin
                        // Drop digits past the last weighted position
                        if (frac_cnt_reg < MAX_DIGIT)
                        begin
                            frac_cnt_next = frac_pos;
                            frac_acc_next = frac_acc_reg + frac_term;
                        end
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                default:
                begin
                    phase_next = PH_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            int_acc_reg   <= '0;
            frac_acc_reg  <= '0;
            frac_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            sat_reg       <= sat_next;
            int_acc_reg   <= int_acc_next;
            frac_acc_reg  <= frac_acc_next;
            frac_cnt_reg  <= frac_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    `ADTF_ASSERT(a_int_acc_capped, int_acc_reg <= INT_CAP)
    `ADTF_ASSERT(a_frac_cnt_bounded, frac_cnt_reg <= MAX_DIGIT)
    `ADTF_ASSERT_IMPL(a_bad_value_zero, out_valid_reg && status_reg == ST_BAD, value_reg == '0)
    `ADTF_ASSERT_NEXT(a_end_restarts, pop_end, out_valid_reg && phase_reg == PH_START)

endmodule

`default_nettype wire

### rtl/ascii_decimal_to_fixed_unit.sv
// Path: a terminator taken into the token queue is popped by the parser, which
//   loads the result register. Throughput: one character per cycle while
//   in_stall is low; the parser retires one token per cycle unless stalled.
// A two-entry token queue keeps input flowing while a finished result is stalled.
// Reset (rst_n low, asynchronous): parser back to start, queue empty, no result.
// ============================================================================
// ascii_decimal_to_fixed_unit
// Streaming ASCII decimal string to signed Q16.16 fixed-point converter.
// ============================================================================
`default_nettype none

module ascii_decimal_to_fixed_unit
    import adtf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [7:0]         character,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic signed [31:0] value,
    output      logic [1:0]         status
);

    logic   queue_full;
    logic   push;
    token_t push_token;
    logic   pop;
    token_t pop_token;
    logic   not_empty;

    adtf_front u_front (
        .character  (character),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_token (push_token)
    );

    adtf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .pop        (pop),
        .pop_token  (pop_token),
        .not_empty  (not_empty)
    );

    adtf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .pop_token  (pop_token),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .status     (status)
    );

endmodule

`default_nettype wire

### tb/sv/ascii_decimal_to_fixed_unit_test.sv
// ============================================================================
// ascii_decimal_to_fixed_unit_test
// Streams ASCII decimal strings into the converter one character per
// transaction. A built-in parser computes the Q16.16 number and status for
// every terminator. Each result the block hands over is checked against the
// oldest pending number. Both handshakes idle and stall at random.
// ============================================================================
module ascii_decimal_to_fixed_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import adtf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 27;
    localparam int TAIL_CYCLES = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int GROWN_W     = INT_BITS + 4;
    localparam int OUT_TOP     = (INT_BITS + FRAC_BITS - 1 > 31) ? 31
                                                                 : INT_BITS + FRAC_BITS - 1;

    typedef enum logic [2:0] {PARSE_START, PARSE_INT, PARSE_FRAC, PARSE_BAD} parse_phase_t;

    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } char_item_t;

    typedef struct {
        logic signed [31:0] value;
        status_t            status;
    } parsed_number_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         character;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] value;
    logic [1:0]         status;

    char_item_t     char_stream[$];
    parsed_number_t expected_numbers[$];

    bit drain_next;
    bit char_taken;
    bit calm;
    int chars_offered;
    int numbers_seen;
    int error_count;
    int cycle_count;

    // Parser state
    parse_phase_t        phase_q    = PARSE_START;
    logic                neg_q      = 1'b0;
    logic [INT_BITS-1:0] int_mag    = '0;
    logic [31:0]         frac_acc   = '0;
    logic [3:0]          frac_count = '0;
    logic [63:0]         frac_scale = 64'd1;
    status_t             sticky     = ST_OK;

    ascii_decimal_to_fixed_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .character (character),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

    always #2 clk = ~clk;

    // Advance the parser by one character; return 1 when a number is complete.
    function automatic bit parse_char(input logic [7:0] ch,
                                      output logic signed [31:0] num,
                                      output status_t st);
        logic [GROWN_W-1:0]  grown;
        logic [63:0]         mag;
        logic [63:0]         limit;
        logic [31:0]         weight;
        logic [3:0]          d;
        bit                  is_digit;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d        = 4'(ch - CH_ZERO);
        num      = '0;
        st       = ST_OK;
        if (ch == CH_NUL)
        begin
            if (phase_q == PARSE_START || phase_q == PARSE_BAD)
            begin
                st = ST_BAD;
            end
            else
            begin
                st    = sticky;
                mag   = (64'(int_mag) << FRAC_BITS) + 64'(frac_acc >> (32 - FRAC_BITS));
                limit = (64'd1 << OUT_TOP) - (neg_q ? 64'd0 : 64'd1);
                if (mag > limit)
                begin
                    mag = limit;
                    st  = ST_SAT;
                end
                num = neg_q ? -mag[31:0] : mag[31:0];
            end
            phase_q    = PARSE_START;
            neg_q      = 1'b0;
            int_mag    = '0;
            frac_acc   = '0;
            frac_count = '0;
            frac_scale = 64'd1;
            sticky     = ST_OK;
            return 1'b1;
        end
        case (phase_q)
            PARSE_START, PARSE_INT:
            begin
                if (phase_q == PARSE_START && (ch == CH_PLUS || ch == CH_MINUS))
                begin
                    neg_q   = (ch == CH_MINUS);
                    phase_q = PARSE_INT;
                end
                else if (ch == CH_DOT)
                begin
                    phase_q = PARSE_FRAC;
                end
                else if (is_digit)
                begin
                    grown = GROWN_W'(int_mag);
                    grown = grown * GROWN_W'(10) + GROWN_W'(d);
                    if (grown > (GROWN_W'(1) << (INT_BITS - 1)))
                    begin
                        grown  = GROWN_W'(1) << (INT_BITS - 1);
                        sticky = ST_SAT;
                    end
                    int_mag = grown[INT_BITS-1:0];
                    phase_q = PARSE_INT;
                end
                else
                begin
                    phase_q = PARSE_BAD;
                end
            end
            PARSE_FRAC:
            begin
                if (!is_digit)
                begin
                    phase_q = PARSE_BAD;
                end
                else if (frac_count < MAX_FRAC_DIGITS)
                begin
                    // weight = round(2^32 / 10^k)
                    frac_count = frac_count + 4'd1;
                    frac_scale = frac_scale * 64'd10;
                    weight     = 32'((((64'd1 << 33) / frac_scale) + 64'd1) >> 1);
                    frac_acc   = frac_acc + d * weight;
                end
            end
            default:
            begin
                phase_q = PARSE_BAD;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic push_char(input logic [7:0] ch);
        char_item_t it;
        it.ch    = ch;
        it.drain = drain_next;
        drain_next = 1'b0;
        char_stream.push_back(it);
    endtask

    task automatic add_string(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i]);
        end
        push_char(CH_NUL);
    endtask

    // Monitor: check the result transaction, then predict from the character transaction.
    always @(posedge clk)
    begin : monitor
        parsed_number_t got;
        parsed_number_t want;
        char_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            numbers_seen++;
            if (expected_numbers.size() == 0)
            begin
                $error("unexpected result: value=%0d status=%0d", value, status);
                error_count++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, value);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
            end
        end
        if (char_taken)
        begin
            if (parse_char(character, got.value, got.status))
                expected_numbers.push_back(got);
        end
    end

    always @(negedge clk)
    begin : driver
        char_item_t it;
        logic       next_valid;
        if (rst_n && !(in_valid && !char_taken))
        begin
            next_valid = 1'b0;
            calm = (chars_offered >= 1100) && (chars_offered < 1400);
            if (char_stream.size() != 0
                && !(char_stream[0].drain && expected_numbers.size() != 0)
                && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                it = char_stream.pop_front();
                character <= it.ch;
                next_valid = 1'b1;
                chars_offered++;
            end
            in_valid <= next_valid;
        end
    end

    always @(negedge clk)
    begin : receiver
        int  hold_left;
        bit  hold_done;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && numbers_seen >= 40)
            begin
                // hold off long enough for the input side to back up
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] word[$];
        int         kind;
        int         pos;
        bit         drained;
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        character = 8'd0;
        out_stall = 1'b0;

        // Directed strings: empty, negative zero, lone sign and point, saturation,
        // most negative value, clamp, excess fraction digits, second sign,
        // second point, non-ASCII character.
        add_string("");
        add_string("-0");
        add_string("+");
        add_string("-.");
        add_string("99999");
        add_string("-32768");
        add_string("32768");
        add_string(".9999999999");
        add_string("+-1");
        add_string("1.2.");
        push_char(8'hFF);
        push_char(CH_ZERO + 8'd5);
        push_char(CH_NUL);

        while (char_stream.size() < 1850)
        begin
            word.delete();
            kind = $urandom_range(99);
            if (!drained && char_stream.size() >= 900)
            begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            if (kind < 8)
            begin
                repeat ($urandom_range(5)) word.push_back(8'($urandom_range(255, 1)));
            end
            else
            begin
                case ($urandom_range(2))
                    1:       word.push_back(CH_PLUS);
                    2:       word.push_back(CH_MINUS);
                    default: ;
                endcase
                if ($urandom_range(7) == 0)
                begin
                    // hover around the integer limit
                    word.push_back(CH_ZERO + 8'd3);
                    word.push_back(CH_ZERO + 8'd2);
                    word.push_back(CH_ZERO + 8'd7);
                    word.push_back(CH_ZERO + 8'd6);
                    word.push_back(8'(CH_ZERO + $urandom_range(9, 6)));
                end
                else
                begin
                    repeat ($urandom_range(5)) word.push_back(8'(CH_ZERO + $urandom_range(9)));
                end
                if ($urandom_range(9) < 7)
                begin
                    word.push_back(CH_DOT);
                    repeat ($urandom_range(11)) word.push_back(8'(CH_ZERO + $urandom_range(9)));
                end
                if (kind < 20)
                begin
                    pos = $urandom_range(word.size());
                    case ($urandom_range(3))
                        0:       word.insert(pos, CH_PLUS);
                        1:       word.insert(pos, CH_MINUS);
                        2:       word.insert(pos, CH_DOT);
                        default: word.insert(pos, 8'($urandom_range(255, 1)));
                    endcase
                end
            end
            foreach (word[i]) push_char(word[i]);
            push_char(CH_NUL);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_stream.size() != 0 || in_valid || expected_numbers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
